// ----- rtl/dwsp_pkg.sv -----
// shared types, widths and register codes for the dual wheel speed pid
`timescale 1ns / 1ps

package dwsp_pkg;

    // default channel count
    localparam int NUM_CHANNELS_DEF = 2;

    // field and datapath widths
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 13;
    localparam int SPEED_W  = 16;
    localparam int ERR_W    = 17;
    localparam int THR_W    = 16;
    localparam int SUM_W    = 14;
    localparam int DIFF_W   = 18;
    localparam int DRIVE_W  = 16;
    localparam int FRAC_W   = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // register reset values
    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 24'd45875;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 24'd3539;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 24'd3408;
    localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 13'd5000;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P    = 2'd0,
        REG_GAIN_I    = 2'd1,
        REG_GAIN_D    = 2'd2,
        REG_INT_LIMIT = 2'd3
    } cfg_reg_t;

    // live configuration
    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    // error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    clear;
        logic                    gate;
    } err_t;

    // integrator stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  isum;
        logic signed [DIFF_W-1:0] diff;
    } integ_t;

endpackage

// ----- rtl/dwsp_err_stage.sv -----
// error, threshold and gate decisions for one transaction
`timescale 1ns / 1ps

module dwsp_err_stage
    import dwsp_pkg::*;
#(
    parameter int CH_W = 1
)
(
    input  logic                      clk,
    input  logic                      adv,
    input  logic [CH_W-1:0]           ch_in,
    input  logic signed [SPEED_W-1:0] target,
    input  logic signed [SPEED_W-1:0] measured,
    output logic [CH_W-1:0]           ch_out,
    output err_t                      result
);

    // 9*t/10 by reciprocal: exact for magnitudes below 2**22
    localparam int T9_W        = SPEED_W + 4;
    localparam int MAG9_W      = SPEED_W + 3;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_MULT  = (2**RECIP_SHIFT + 9) / 10;
    localparam int PROD_W      = MAG9_W + 21;

    logic signed [T9_W-1:0]   t_ext;
    logic signed [T9_W-1:0]   t9;
    logic [MAG9_W-1:0]        mag9;
    logic [PROD_W-1:0]        quot_prod;
    logic [THR_W-1:0]         quot;
    logic signed [THR_W-1:0]  thr;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         err_mag;
    logic signed [ERR_W:0]    mag_cmp;
    logic signed [ERR_W:0]    thr_cmp;
    logic signed [ERR_W:0]    err_cmp;
    err_t                     result_next;
    err_t                     result_reg;
    logic [CH_W-1:0]          ch_reg;

    // threshold
    always_comb
    begin
        t_ext     = {{(T9_W-SPEED_W){target[SPEED_W-1]}}, target};
        t9        = (t_ext <<< 3) + t_ext;
        mag9      = t9[T9_W-1] ? MAG9_W'(-t9) : t9[MAG9_W-1:0];
        quot_prod = PROD_W'(mag9) * PROD_W'(RECIP_MULT);
        quot      = quot_prod[RECIP_SHIFT +: THR_W];
        thr       = t9[T9_W-1] ? -$signed(quot) : $signed(quot);
    end

    // error and decisions
    always_comb
    begin
        err     = {target[SPEED_W-1], target} - {measured[SPEED_W-1], measured};
        err_mag = err[ERR_W-1] ? ERR_W'(-err) : err;
        mag_cmp = $signed({1'b0, err_mag});
        thr_cmp = {{(ERR_W+1-THR_W){thr[THR_W-1]}}, thr};
        err_cmp = {err[ERR_W-1], err};
        result_next.err   = err;
        result_next.clear = (err_cmp >= thr_cmp);
        result_next.gate  = !(mag_cmp >= thr_cmp);
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
            ch_reg     <= ch_in;
        end
    end

    assign result = result_reg;
    assign ch_out = ch_reg;

endmodule

// ----- rtl/dwsp_integ_stage.sv -----
// per-channel integrator and derivative state with the stage register
`timescale 1ns / 1ps

module dwsp_integ_stage
    import dwsp_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int CH_W         = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               valid,
    input  logic [CH_W-1:0]    ch,
    input  err_t               in_data,
    input  logic [LIMIT_W-1:0] limit,
    output integ_t             result
);

    localparam int ACC_W = ERR_W + 1;

    logic signed [SUM_W-1:0] sum_reg  [NUM_CHANNELS];
    logic signed [ERR_W-1:0] prev_reg [NUM_CHANNELS];
    logic signed [SUM_W-1:0] sum_cur;
    logic signed [ERR_W-1:0] prev_cur;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lim_pos;
    logic signed [ACC_W-1:0] lim_neg;
    logic signed [ACC_W-1:0] acc_clamped;
    logic signed [SUM_W-1:0] sum_next;
    integ_t                  result_next;
    integ_t                  result_reg;

    assign sum_cur  = sum_reg[ch];
    assign prev_cur = prev_reg[ch];

    // accumulate, clamp, then clear
    always_comb
    begin
        acc     = {{(ACC_W-SUM_W){sum_cur[SUM_W-1]}}, sum_cur}
                + {in_data.err[ERR_W-1], in_data.err};
        lim_pos = $signed({{(ACC_W-LIMIT_W){1'b0}}, limit});
        lim_neg = -lim_pos;
        acc_clamped = acc;
        if (acc >= lim_pos)
        begin
            acc_clamped = lim_pos;
        end
        if (acc < lim_neg)
        begin
            acc_clamped = lim_neg;
        end
        if (in_data.clear)
        begin
            acc_clamped = '0;
        end
        sum_next = acc_clamped[SUM_W-1:0];

        result_next.err  = in_data.err;
        result_next.isum = in_data.gate ? sum_next : '0;
        result_next.diff = {in_data.err[ERR_W-1], in_data.err}
                         - {prev_cur[ERR_W-1], prev_cur};
    end

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                sum_reg[k]  <= '0;
                prev_reg[k] <= '0;
            end
        end
        else if (adv && valid)
        begin
            sum_reg[ch]  <= sum_next;
            prev_reg[ch] <= in_data.err;
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/dwsp_mac_stage.sv -----
// gain products, sum, truncation and saturation of the drive value
`timescale 1ns / 1ps

module dwsp_mac_stage
    import dwsp_pkg::*;
(
    input  logic                      clk,
    input  logic                      adv,
    input  integ_t                    in_data,
    input  cfg_t                      cfg,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      saturated
);

    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int PI_W  = GAIN_W + 1 + SUM_W;
    localparam int PD_W  = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W = PD_W + 2;
    localparam int Q_W   = ACC_W - FRAC_W;

    logic signed [GAIN_W:0]        gp;
    logic signed [GAIN_W:0]        gi;
    logic signed [GAIN_W:0]        gd;
    logic signed [PP_W-1:0]        pp_next;
    logic signed [PI_W-1:0]        pi_next;
    logic signed [PD_W-1:0]        pd_next;
    logic signed [PP_W-1:0]        pp_reg;
    logic signed [PI_W-1:0]        pi_reg;
    logic signed [PD_W-1:0]        pd_reg;
    logic signed [ACC_W-1:0]       acc;
    logic signed [Q_W-1:0]         q_floor;
    logic signed [Q_W-1:0]         q;
    logic                          round_up;
    logic signed [DRIVE_W-1:0]     drive_next;
    logic                          sat_next;
    logic signed [DRIVE_W-1:0]     drive_reg;
    logic                          sat_reg;

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(2**(DRIVE_W-1) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(2**(DRIVE_W-1));

    // products
    always_comb
    begin
        gp      = $signed({1'b0, cfg.gain_p});
        gi      = $signed({1'b0, cfg.gain_i});
        gd      = $signed({1'b0, cfg.gain_d});
        pp_next = gp * in_data.err;
        pi_next = gi * in_data.isum;
        pd_next = gd * in_data.diff;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
        end
    end

    // sum, truncate toward zero, saturate
    always_comb
    begin
        acc      = {{(ACC_W-PP_W){pp_reg[PP_W-1]}}, pp_reg}
                 + {{(ACC_W-PI_W){pi_reg[PI_W-1]}}, pi_reg}
                 + {{(ACC_W-PD_W){pd_reg[PD_W-1]}}, pd_reg};
        q_floor  = acc[ACC_W-1:FRAC_W];
        round_up = acc[ACC_W-1] && (|acc[FRAC_W-1:0]);
        q        = q_floor + $signed({{(Q_W-1){1'b0}}, round_up});
        drive_next = q[DRIVE_W-1:0];
        sat_next   = 1'b0;
        if (q > Q_MAX)
        begin
            drive_next = Q_MAX[DRIVE_W-1:0];
            sat_next   = 1'b1;
        end
        else if (q < Q_MIN)
        begin
            drive_next = Q_MIN[DRIVE_W-1:0];
            sat_next   = 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assign drive     = drive_reg;
    assign saturated = sat_reg;

endmodule

// ----- rtl/dual_wheel_speed_pid.sv -----
// top level of the two-wheel speed pid with integrator clamp and gating
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  config   | cfg_write            | cfg_index, cfg_data
//  input    | in_valid / in_stall  | channel, target_speed, measured_speed
//  output   | out_valid / out_stall| drive, drive_saturated
//
// one transaction per cycle while out_stall does not freeze the pipe; five register
// stages from input to result: input, error, integrator, product and result.
// channel state is read and written in the integrator stage, so items on
// the same channel in consecutive cycles see each other's updates.
// a held result under out_stall freezes the whole pipe and raises in_stall.
// reset loads the default gains and limit, clears channel state and all valid bits.
`timescale 1ns / 1ps

module dual_wheel_speed_pid
    import dwsp_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      channel,
    input  logic signed [SPEED_W-1:0] target_speed,
    input  logic signed [SPEED_W-1:0] measured_speed,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      drive_saturated
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    cfg_t                      cfg_reg;
    logic                      adv;
    logic                      v0_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      vo_reg;
    logic [CH_W-1:0]           ch_next;
    logic [CH_W-1:0]           ch0_reg;
    logic signed [SPEED_W-1:0] tgt0_reg;
    logic signed [SPEED_W-1:0] meas0_reg;
    logic [CH_W-1:0]           ch1;
    err_t                      err_data;
    integ_t                    integ_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p <= GAIN_P_RST;
            cfg_reg.gain_i <= GAIN_I_RST;
            cfg_reg.gain_d <= GAIN_D_RST;
            cfg_reg.limit  <= INT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:    cfg_reg.gain_p <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    cfg_reg.gain_i <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    cfg_reg.gain_d <= cfg_data[GAIN_W-1:0];
                REG_INT_LIMIT: cfg_reg.limit  <= cfg_data[LIMIT_W-1:0];
                default:       cfg_reg.limit  <= cfg_reg.limit;
            endcase
        end
    end

    // pipe moves unless a held result is stalled
    assign adv      = !(vo_reg && out_stall);
    assign in_stall = !adv;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // channel index wraps onto the channel count
    assign ch_next = (NUM_CHANNELS > 1) ? CH_W'(channel) : '0;

    // input register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ch0_reg   <= ch_next;
            tgt0_reg  <= target_speed;
            meas0_reg <= measured_speed;
        end
    end

    dwsp_err_stage #(
        .CH_W (CH_W)
    ) u_err (
        .clk      (clk),
        .adv      (adv),
        .ch_in    (ch0_reg),
        .target   (tgt0_reg),
        .measured (meas0_reg),
        .ch_out   (ch1),
        .result   (err_data)
    );

    dwsp_integ_stage #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_W         (CH_W)
    ) u_integ (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .valid   (v1_reg),
        .ch      (ch1),
        .in_data (err_data),
        .limit   (cfg_reg.limit),
        .result  (integ_data)
    );

    dwsp_mac_stage u_mac (
        .clk       (clk),
        .adv       (adv),
        .in_data   (integ_data),
        .cfg       (cfg_reg),
        .drive     (drive),
        .saturated (drive_saturated)
    );

    assign out_valid = vo_reg;

endmodule

// ----- rtl/dwsp_checker.sv -----
// port-level checks for the dual wheel speed pid, bound to the top level
`timescale 1ns / 1ps

module dwsp_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] drive,
    input  logic               drive_saturated
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive) && $stable(drive_saturated))
        else $error("stalled result changed");

    // saturation flag only with a rail value
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_saturated |-> (drive == 16'sh7fff) || (drive == 16'sh8000))
        else $error("saturation flag without rail value");

    // a stalled result back-pressures the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while result stalled");

    // an accepted transaction comes out when out_stall stays low while it passes the stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind dual_wheel_speed_pid dwsp_checker u_dwsp_checker (.*);
